// ===== hw/rtl/rfi_pkg.sv =====
// Shared types, constants and fixed-point helpers for the reflection-from-impedance block.
package rfi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 24;
  localparam int K0_BITS = 23;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int DIV_V_BITS = WORD_BITS + FRAC_BITS;
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS = WORD_BITS / DIV_BITS_PER_STEP;
  localparam int DIV_LAT = DIV_STEPS + 2;
  localparam int SQ_REM_BITS = WORD_BITS + 2;
  localparam int PIPE_LAT = 2 * DIV_LAT + 13;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0] umag_t;
  typedef logic [PROD_BITS-1:0] prod_t;
  typedef logic [K0_BITS-1:0] k0_t;
  typedef logic [1:0] stat_t;

  typedef struct packed {
    logic neg;
    prod_t mag;
  } rprod_t;

  typedef struct packed {
    word_t re;
    word_t im;
  } cplx_t;

  typedef struct packed {
    rprod_t rr;
    rprod_t ii;
    rprod_t ri;
    rprod_t ir;
  } craw_t;

  typedef struct packed {
    logic graz;
    logic kx_zero;
    logic ky_zero;
  } flag_t;

  localparam stat_t ST_NORMAL = 2'd0;
  localparam stat_t ST_GRAZING = 2'd1;
  localparam stat_t ST_SINGULAR = 2'd2;

  localparam k0_t K0_RESET = k0_t'(65536);
  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_Q = word_t'(1) << FRAC_BITS;

  function automatic umag_t mag(word_t v);
    return v[WORD_BITS-1] ? umag_t'(-v) : umag_t'(v);
  endfunction

  // clamp a magnitude to the signed word range, then apply the sign
  function automatic word_t from_mag(logic neg, prod_t m);
    prod_t lim;
    umag_t v;
    lim = neg ? (prod_t'(1) << (WORD_BITS-1)) : ((prod_t'(1) << (WORD_BITS-1)) - prod_t'(1));
    v = (m > lim) ? lim[WORD_BITS-1:0] : m[WORD_BITS-1:0];
    return neg ? word_t'(-v) : word_t'(v);
  endfunction

  function automatic rprod_t rmul(word_t a, word_t b);
    rprod_t r;
    r.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    r.mag = prod_t'(mag(a)) * prod_t'(mag(b));
    return r;
  endfunction

  // round half away from zero, drop fraction bits, saturate
  function automatic word_t mq_fin(rprod_t x);
    logic [PROD_BITS:0] t;
    t = {1'b0, x.mag} + ((PROD_BITS+1)'(1) << (FRAC_BITS-1));
    return from_mag(x.neg, prod_t'(t >> FRAC_BITS));
  endfunction

  function automatic word_t sat_wide(logic [WORD_BITS:0] v);
    if (v[WORD_BITS] != v[WORD_BITS-1]) return v[WORD_BITS] ? WORD_MIN : WORD_MAX;
    return word_t'(v[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sadd(word_t a, word_t b);
    return sat_wide({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
  endfunction

  function automatic word_t ssub(word_t a, word_t b);
    return sat_wide({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
  endfunction

  function automatic word_t sneg(word_t a);
    return ssub('0, a);
  endfunction

  function automatic cplx_t csub(cplx_t a, cplx_t b);
    return {ssub(a.re, b.re), ssub(a.im, b.im)};
  endfunction

  function automatic craw_t cmul_raw(cplx_t a, cplx_t b);
    craw_t r;
    r.rr = rmul(a.re, b.re);
    r.ii = rmul(a.im, b.im);
    r.ri = rmul(a.re, b.im);
    r.ir = rmul(a.im, b.re);
    return r;
  endfunction

  function automatic cplx_t cmul_fin(craw_t x);
    return {ssub(mq_fin(x.rr), mq_fin(x.ii)), sadd(mq_fin(x.ri), mq_fin(x.ir))};
  endfunction

endpackage

// ===== hw/rtl/rfi_div.sv =====
// Pipelined rounding fixed-point divider, two quotient bits per stage.
module rfi_div (
  input  logic          clk,
  input  rfi_pkg::word_t num,
  input  rfi_pkg::k0_t   den,
  output rfi_pkg::word_t quo
);
  import rfi_pkg::*;

  logic [DIV_V_BITS-1:0] v;
  logic ovf_nxt;
  logic zro_nxt;

  k0_t   rem_r [0:DIV_STEPS];
  umag_t lo_r  [0:DIV_STEPS];
  umag_t q_r   [0:DIV_STEPS];
  k0_t   d_r   [0:DIV_STEPS];
  logic  neg_r [0:DIV_STEPS];
  logic  ovf_r [0:DIV_STEPS];
  logic  zro_r [0:DIV_STEPS];
  word_t quo_r;

  // dividend is |num| scaled by 2^FRAC plus half the divisor for rounding
  always_comb begin
    v = {mag(num), FRAC_BITS'(0)} + DIV_V_BITS'(den >> 1);
    ovf_nxt = K0_BITS'(v[DIV_V_BITS-1:WORD_BITS]) >= den;
    zro_nxt = (den == '0) && (num == '0);
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= K0_BITS'(v[DIV_V_BITS-1:WORD_BITS]);
    lo_r[0]  <= v[WORD_BITS-1:0];
    q_r[0]   <= '0;
    d_r[0]   <= den;
    neg_r[0] <= num[WORD_BITS-1];
    ovf_r[0] <= ovf_nxt;
    zro_r[0] <= zro_nxt;
  end

  for (genvar g = 1; g <= DIV_STEPS; g++) begin : gen_stage
    k0_t   rem_nxt;
    umag_t lo_nxt;
    umag_t q_nxt;

    always_comb begin : step
      logic [K0_BITS:0] sh;
      k0_t   rm;
      umag_t lo;
      umag_t q;
      rm = rem_r[g-1];
      lo = lo_r[g-1];
      q  = q_r[g-1];
      for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
        sh = {rm, lo[WORD_BITS-1]};
        lo = {lo[WORD_BITS-2:0], 1'b0};
        if (sh >= {1'b0, d_r[g-1]}) begin
          sh = sh - {1'b0, d_r[g-1]};
          q  = {q[WORD_BITS-2:0], 1'b1};
        end else begin
          q  = {q[WORD_BITS-2:0], 1'b0};
        end
        rm = sh[K0_BITS-1:0];
      end
      rem_nxt = rm;
      lo_nxt  = lo;
      q_nxt   = q;
    end

    always_ff @(posedge clk) begin
      rem_r[g] <= rem_nxt;
      lo_r[g]  <= lo_nxt;
      q_r[g]   <= q_nxt;
      d_r[g]   <= d_r[g-1];
      neg_r[g] <= neg_r[g-1];
      ovf_r[g] <= ovf_r[g-1];
      zro_r[g] <= zro_r[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (zro_r[DIV_STEPS]) begin
      quo_r <= '0;
    end else begin
      quo_r <= from_mag(neg_r[DIV_STEPS],
                        ovf_r[DIV_STEPS] ? (prod_t'(1) << WORD_BITS) : prod_t'(q_r[DIV_STEPS]));
    end
  end

  assign quo = quo_r;

endmodule

// ===== hw/rtl/reflection_from_impedance_2x2.sv =====
// Top level: 2x2 reflection matrix from impedance at one spectral point.
//
// Fully pipelined: one point is accepted every cycle (busy stays low) and its
// result appears on the out_ ports, flagged by out_strobe for one cycle.
// The path runs through two sets of pipelined dividers (two quotient bits
// per stage): one forms H = (k0^2 - k^2)/k0, the other the final scaling
// by |det|^2, with the multiply/round stages around them. The receiver
// cannot stall, so nothing ever backs up. Write k0 (cfg_data) only while
// no point is in flight; cfg_ready is always high. Grazing points (s == 0)
// report status 1 with a fixed +-1 diagonal, a singular determinant reports
// status 2 with zeros.
module reflection_from_impedance_2x2 (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rfi_pkg::word_t in_kx,
  input  rfi_pkg::word_t in_ky,
  input  rfi_pkg::word_t in_z00_re,
  input  rfi_pkg::word_t in_z00_im,
  input  rfi_pkg::word_t in_z01_re,
  input  rfi_pkg::word_t in_z01_im,
  input  rfi_pkg::word_t in_z10_re,
  input  rfi_pkg::word_t in_z10_im,
  input  rfi_pkg::word_t in_z11_re,
  input  rfi_pkg::word_t in_z11_im,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  rfi_pkg::k0_t   cfg_data,
  output logic           out_strobe,
  output rfi_pkg::word_t out_r00_re,
  output rfi_pkg::word_t out_r00_im,
  output rfi_pkg::word_t out_r01_re,
  output rfi_pkg::word_t out_r01_im,
  output rfi_pkg::word_t out_r10_re,
  output rfi_pkg::word_t out_r10_im,
  output rfi_pkg::word_t out_r11_re,
  output rfi_pkg::word_t out_r11_im,
  output rfi_pkg::stat_t out_status
);
  import rfi_pkg::*;

  typedef struct packed {
    cplx_t [1:0][1:0] z;
    logic s_pos;
    flag_t flg;
  } sb1_t;

  typedef struct packed {
    flag_t flg;
    logic sing;
  } sb2_t;

  // control
  k0_t k0_r;
  logic [PIPE_LAT-1:0] vld_r;

  // front end: k^2 terms
  word_t kx_r, ky_r;
  cplx_t [1:0][1:0] z0_r, z1_r, z2_r;
  rprod_t pk0_r, pkx_r, pky_r, pkxy_r;
  logic kxz1_r, kyz1_r, kxz2_r, kyz2_r;
  word_t k02_r, kx2_r, ky2_r, kxy_r;
  word_t s_nxt;
  word_t s_r, h00n_r, h01n_r, h11n_r;
  sb1_t sb1_r [0:DIV_LAT];

  // H dividers and square root
  word_t h00_q, h01_q, h11_q;
  prod_t sq_v_r    [0:DIV_STEPS];
  logic [SQ_REM_BITS-1:0] sq_rem_r [0:DIV_STEPS];
  umag_t sq_root_r [0:DIV_STEPS];
  umag_t root_r;

  // matrix part
  cplx_t c17;
  word_t h17 [0:1][0:1];
  rprod_t wraw_r [0:1][0:1][0:3];
  cplx_t c18_r, c19_r;
  flag_t f18_r, f19_r, f20_r, f21_r, f22_r, f23_r, f24_r;
  cplx_t w_r [0:1][0:1];
  cplx_t m_r [0:1][0:1];
  cplx_t n_r [0:1][0:1];
  craw_t cr_r [0:9];
  cplx_t cm_r [0:9];
  cplx_t det_r;
  cplx_t p_r [0:3];
  rprod_t drr_r, dii_r;
  craw_t qraw_r [0:3];
  word_t den_nxt;
  word_t den_r;
  cplx_t q_r [0:3];
  sb2_t sb2_r [0:DIV_LAT];
  word_t fq_re [0:3];
  word_t fq_im [0:3];

  // output
  word_t res_r [0:7];
  stat_t stat_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k0_r  <= K0_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_valid) k0_r <= cfg_data;
      vld_r <= {vld_r[PIPE_LAT-2:0], start & ~busy};
    end
  end

  // ---- stages 0..3: squares, s and H numerators ----
  always_comb begin
    s_nxt = ssub(ssub(k02_r, kx2_r), ky2_r);
  end

  always_ff @(posedge clk) begin
    kx_r <= in_kx;
    ky_r <= in_ky;
    z0_r[0][0] <= {in_z00_re, in_z00_im};
    z0_r[0][1] <= {in_z01_re, in_z01_im};
    z0_r[1][0] <= {in_z10_re, in_z10_im};
    z0_r[1][1] <= {in_z11_re, in_z11_im};

    pk0_r  <= rmul(word_t'(k0_r), word_t'(k0_r));
    pkx_r  <= rmul(kx_r, kx_r);
    pky_r  <= rmul(ky_r, ky_r);
    pkxy_r <= rmul(kx_r, ky_r);
    kxz1_r <= (kx_r == '0);
    kyz1_r <= (ky_r == '0);
    z1_r   <= z0_r;

    k02_r  <= mq_fin(pk0_r);
    kx2_r  <= mq_fin(pkx_r);
    ky2_r  <= mq_fin(pky_r);
    kxy_r  <= mq_fin(pkxy_r);
    kxz2_r <= kxz1_r;
    kyz2_r <= kyz1_r;
    z2_r   <= z1_r;

    s_r    <= s_nxt;
    h00n_r <= ssub(k02_r, ky2_r);
    h11n_r <= ssub(k02_r, kx2_r);
    h01n_r <= kxy_r;
    sb1_r[0] <= {z2_r, ~s_nxt[WORD_BITS-1] && (s_nxt != '0),
                 s_nxt == '0, kxz2_r, kyz2_r};
    for (int i = 1; i <= DIV_LAT; i++) sb1_r[i] <= sb1_r[i-1];
  end

  rfi_div u_div_h00 (.clk(clk), .num(h00n_r), .den(k0_r), .quo(h00_q));
  rfi_div u_div_h01 (.clk(clk), .num(h01n_r), .den(k0_r), .quo(h01_q));
  rfi_div u_div_h11 (.clk(clk), .num(h11n_r), .den(k0_r), .quo(h11_q));

  // ---- square root of |s| * 2^FRAC, two root bits per stage ----
  always_ff @(posedge clk) begin
    sq_v_r[0]    <= prod_t'(mag(s_r)) << FRAC_BITS;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  for (genvar g = 1; g <= DIV_STEPS; g++) begin : gen_sqrt
    prod_t v_nxt;
    logic [SQ_REM_BITS-1:0] rem_nxt;
    umag_t root_nxt;

    always_comb begin : step
      logic [SQ_REM_BITS+1:0] sh;
      logic [SQ_REM_BITS+1:0] trial;
      logic [SQ_REM_BITS-1:0] rm;
      umag_t rt;
      prod_t vv;
      rm = sq_rem_r[g-1];
      rt = sq_root_r[g-1];
      vv = sq_v_r[g-1];
      for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
        sh = {rm, vv[PROD_BITS-1 -: 2]};
        vv = vv << 2;
        trial = (SQ_REM_BITS+2)'({rt, 2'b01});
        if (sh >= trial) begin
          sh = sh - trial;
          rt = {rt[WORD_BITS-2:0], 1'b1};
        end else begin
          rt = {rt[WORD_BITS-2:0], 1'b0};
        end
        rm = sh[SQ_REM_BITS-1:0];
      end
      v_nxt    = vv;
      rem_nxt  = rm;
      root_nxt = rt;
    end

    always_ff @(posedge clk) begin
      sq_v_r[g]    <= v_nxt;
      sq_rem_r[g]  <= rem_nxt;
      sq_root_r[g] <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_r <= sq_root_r[DIV_STEPS];
  end

  // ---- c = i*k3 and H, aligned with the divider outputs ----
  always_comb begin
    c17.re = sb1_r[DIV_LAT].s_pos ? '0 : word_t'(root_r);
    c17.im = sb1_r[DIV_LAT].s_pos ? word_t'(root_r) : '0;
    h17[0][0] = h00_q;
    h17[0][1] = h01_q;
    h17[1][0] = h01_q;
    h17[1][1] = h11_q;
  end

  // ---- W = i*Z*H, M = cI + W, N = cI - W ----
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        wraw_r[a][b][0] <= rmul(sb1_r[DIV_LAT].z[a][0].im, h17[0][b]);
        wraw_r[a][b][1] <= rmul(sb1_r[DIV_LAT].z[a][1].im, h17[1][b]);
        wraw_r[a][b][2] <= rmul(sb1_r[DIV_LAT].z[a][0].re, h17[0][b]);
        wraw_r[a][b][3] <= rmul(sb1_r[DIV_LAT].z[a][1].re, h17[1][b]);
      end
    end
    c18_r <= c17;
    f18_r <= sb1_r[DIV_LAT].flg;

    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        w_r[a][b].re <= sneg(sadd(mq_fin(wraw_r[a][b][0]), mq_fin(wraw_r[a][b][1])));
        w_r[a][b].im <= sadd(mq_fin(wraw_r[a][b][2]), mq_fin(wraw_r[a][b][3]));
      end
    end
    c19_r <= c18_r;
    f19_r <= f18_r;

    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        if (a == b) begin
          m_r[a][b] <= {sadd(c19_r.re, w_r[a][b].re), sadd(c19_r.im, w_r[a][b].im)};
          n_r[a][b] <= {ssub(c19_r.re, w_r[a][b].re), ssub(c19_r.im, w_r[a][b].im)};
        end else begin
          m_r[a][b] <= w_r[a][b];
          n_r[a][b] <= {sneg(w_r[a][b].re), sneg(w_r[a][b].im)};
        end
      end
    end
    f20_r <= f19_r;
  end

  // ---- det(M) and adj(M)*N ----
  always_ff @(posedge clk) begin
    cr_r[0] <= cmul_raw(m_r[0][0], m_r[1][1]);
    cr_r[1] <= cmul_raw(m_r[0][1], m_r[1][0]);
    cr_r[2] <= cmul_raw(m_r[1][1], n_r[0][0]);
    cr_r[3] <= cmul_raw(m_r[0][1], n_r[1][0]);
    cr_r[4] <= cmul_raw(m_r[1][1], n_r[0][1]);
    cr_r[5] <= cmul_raw(m_r[0][1], n_r[1][1]);
    cr_r[6] <= cmul_raw(m_r[0][0], n_r[1][0]);
    cr_r[7] <= cmul_raw(m_r[1][0], n_r[0][0]);
    cr_r[8] <= cmul_raw(m_r[0][0], n_r[1][1]);
    cr_r[9] <= cmul_raw(m_r[1][0], n_r[0][1]);
    f21_r <= f20_r;

    for (int i = 0; i < 10; i++) cm_r[i] <= cmul_fin(cr_r[i]);
    f22_r <= f21_r;

    det_r <= csub(cm_r[0], cm_r[1]);
    for (int k = 0; k < 4; k++) p_r[k] <= csub(cm_r[2+2*k], cm_r[3+2*k]);
    f23_r <= f22_r;

    // |det|^2 and P * conj(det)
    drr_r <= rmul(det_r.re, det_r.re);
    dii_r <= rmul(det_r.im, det_r.im);
    for (int k = 0; k < 4; k++) qraw_r[k] <= cmul_raw(p_r[k], {det_r.re, sneg(det_r.im)});
    f24_r <= f23_r;
  end

  always_comb begin
    den_nxt = sadd(mq_fin(drr_r), mq_fin(dii_r));
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    for (int k = 0; k < 4; k++) q_r[k] <= cmul_fin(qraw_r[k]);
    sb2_r[0] <= {f24_r, den_nxt[WORD_BITS-1] || (den_nxt == '0)};
    for (int i = 1; i <= DIV_LAT; i++) sb2_r[i] <= sb2_r[i-1];
  end

  // den is only used when positive, so it fits the unsigned divisor width
  for (genvar k = 0; k < 4; k++) begin : gen_fdiv
    rfi_div u_div_re (.clk(clk), .num(q_r[k].re), .den(den_r[K0_BITS-1:0]), .quo(fq_re[k]));
    rfi_div u_div_im (.clk(clk), .num(q_r[k].im), .den(den_r[K0_BITS-1:0]), .quo(fq_im[k]));
  end

  // ---- output select ----
  always_ff @(posedge clk) begin
    if (sb2_r[DIV_LAT].flg.graz) begin
      res_r[0] <= sb2_r[DIV_LAT].flg.ky_zero ? word_t'(-ONE_Q) : ONE_Q;
      for (int j = 1; j < 6; j++) res_r[j] <= '0;
      res_r[6] <= (sb2_r[DIV_LAT].flg.kx_zero && !sb2_r[DIV_LAT].flg.ky_zero) ?
                  word_t'(-ONE_Q) : ONE_Q;
      res_r[7] <= '0;
      stat_r <= ST_GRAZING;
    end else if (sb2_r[DIV_LAT].sing) begin
      for (int j = 0; j < 8; j++) res_r[j] <= '0;
      stat_r <= ST_SINGULAR;
    end else begin
      for (int k = 0; k < 4; k++) begin
        res_r[2*k]   <= fq_re[k];
        res_r[2*k+1] <= fq_im[k];
      end
      stat_r <= ST_NORMAL;
    end
  end

  assign out_strobe = vld_r[PIPE_LAT-1];
  assign out_r00_re = res_r[0];
  assign out_r00_im = res_r[1];
  assign out_r01_re = res_r[2];
  assign out_r01_im = res_r[3];
  assign out_r10_re = res_r[4];
  assign out_r10_im = res_r[5];
  assign out_r11_re = res_r[6];
  assign out_r11_im = res_r[7];
  assign out_status = stat_r;

endmodule

// ===== hw/rtl/rfi_chk.sv =====
// Port-level checker for the reflection-from-impedance block, bound to the top level.
module rfi_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_strobe,
  input rfi_pkg::word_t out_r00_re,
  input rfi_pkg::word_t out_r00_im,
  input rfi_pkg::word_t out_r01_re,
  input rfi_pkg::word_t out_r01_im,
  input rfi_pkg::word_t out_r10_re,
  input rfi_pkg::word_t out_r10_im,
  input rfi_pkg::word_t out_r11_re,
  input rfi_pkg::word_t out_r11_im,
  input rfi_pkg::stat_t out_status
);
  import rfi_pkg::*;

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_strobe)
    else $error("accepted beat produced no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching input beat");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_status == ST_NORMAL || out_status == ST_GRAZING ||
                    out_status == ST_SINGULAR))
    else $error("illegal status code");

  a_grazing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_GRAZING) |->
      (out_r00_im == '0 && out_r01_re == '0 && out_r01_im == '0 &&
       out_r10_re == '0 && out_r10_im == '0 && out_r11_im == '0 &&
       (out_r00_re == ONE_Q || out_r00_re == word_t'(-ONE_Q)) &&
       (out_r11_re == ONE_Q || out_r11_re == word_t'(-ONE_Q))))
    else $error("grazing result is not a unit diagonal");

  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_SINGULAR) |->
      (out_r00_re == '0 && out_r00_im == '0 && out_r01_re == '0 && out_r01_im == '0 &&
       out_r10_re == '0 && out_r10_im == '0 && out_r11_re == '0 && out_r11_im == '0))
    else $error("singular result is not zero");

endmodule

bind reflection_from_impedance_2x2 rfi_chk u_rfi_chk (.*);
